// ===== hdl/fcu_pkg.sv =====
// ----------------------------------------------------------------------------
// fcu_pkg
// Shared widths, limits and the job record passed from front to back.
// ----------------------------------------------------------------------------
package fcu_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned IndexW    = 12;
  localparam int unsigned WidthW    = 13;
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned ColW      = 12;
  localparam int unsigned LastColW  = 11;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;
  localparam int unsigned QueueCntW = 2;

  localparam logic [WidthW-1:0] LineWidthReset = WidthW'(1);

  // one accepted chroma column, classified for the back end
  typedef struct packed {
    logic [SampleW-1:0] above_u;
    logic [SampleW-1:0] above_v;
    logic [SampleW-1:0] here_u;
    logic [SampleW-1:0] here_v;
    logic [SampleW-1:0] prev_above_u;
    logic [SampleW-1:0] prev_above_v;
    logic [SampleW-1:0] prev_here_u;
    logic [SampleW-1:0] prev_here_v;
    logic               want_top;
    logic               want_bottom;
    logic               first_col;
    logic               last_col;
    logic [IndexW-1:0]  base_index;
    logic [1:0]         num_results;
  } fcu_job_t;

  typedef struct packed {
    logic [IndexW-1:0]  pixel_index;
    logic [SampleW-1:0] top_u;
    logic [SampleW-1:0] top_v;
    logic [SampleW-1:0] bottom_u;
    logic [SampleW-1:0] bottom_v;
    logic               top_valid;
    logic               bottom_valid;
    logic               line_end;
  } fcu_result_t;

endpackage

// ===== hdl/fcu_front.sv =====
// ----------------------------------------------------------------------------
// fcu_front
// Accepts chroma columns, tracks the column position in the line and builds
// one job per column with the previous column attached.
// ----------------------------------------------------------------------------
module fcu_front import fcu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WidthW-1:0]  cfg_wdata_i,
  input  logic               push_i,
  input  logic [SampleW-1:0] above_u_i,
  input  logic [SampleW-1:0] above_v_i,
  input  logic [SampleW-1:0] here_u_i,
  input  logic [SampleW-1:0] here_v_i,
  input  logic               want_top_i,
  input  logic               want_bottom_i,
  output fcu_job_t           job_o
);

  logic [WidthW-1:0]   line_width_q, line_width_d;
  logic [2*SampleW-1:0] prev_above_q, prev_above_d;
  logic [2*SampleW-1:0] prev_here_q, prev_here_d;
  logic [ColW-1:0]     col_q, col_d;

  logic [WidthW-1:0]   width_eff;
  logic [LastColW-1:0] last_col;
  logic                even_width;
  logic [ColW-1:0]     col;
  logic                is_first;
  logic                is_last;

  always_comb begin
    priority if (line_width_q == '0) begin
      width_eff = WidthW'(1);
    end else if (line_width_q > WidthW'(MaxWidth)) begin
      width_eff = WidthW'(MaxWidth);
    end else begin
      width_eff = line_width_q;
    end
  end

  assign last_col   = LastColW'((width_eff - WidthW'(1)) >> 1);
  assign even_width = ~width_eff[0];
  // a counter left beyond a narrowed line restarts at column zero
  assign col        = (col_q > ColW'(last_col)) ? '0 : col_q;
  assign is_first   = (col == '0);
  assign is_last    = (col == ColW'(last_col));

  always_comb begin
    job_o.above_u      = above_u_i;
    job_o.above_v      = above_v_i;
    job_o.here_u       = here_u_i;
    job_o.here_v       = here_v_i;
    job_o.prev_above_u = prev_above_q[SampleW-1:0];
    job_o.prev_above_v = prev_above_q[2*SampleW-1:SampleW];
    job_o.prev_here_u  = prev_here_q[SampleW-1:0];
    job_o.prev_here_v  = prev_here_q[2*SampleW-1:SampleW];
    job_o.want_top     = want_top_i;
    job_o.want_bottom  = want_bottom_i;
    job_o.first_col    = is_first;
    job_o.last_col     = is_last;
    job_o.base_index   = is_first ? '0 : ({col[IndexW-2:0], 1'b0} - IndexW'(1));
    if (is_first) begin
      job_o.num_results = (is_last && even_width) ? 2'd2 : 2'd1;
    end else begin
      job_o.num_results = (is_last && even_width) ? 2'd3 : 2'd2;
    end
  end

  always_comb begin
    line_width_d = cfg_we_i ? cfg_wdata_i : line_width_q;
    prev_above_d = prev_above_q;
    prev_here_d  = prev_here_q;
    col_d        = col_q;
    if (push_i) begin
      prev_above_d = {above_v_i, above_u_i};
      prev_here_d  = {here_v_i, here_u_i};
      col_d        = is_last ? '0 : (col + ColW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
      prev_above_q <= '0;
      prev_here_q  <= '0;
      col_q        <= '0;
    end else begin
      line_width_q <= line_width_d;
      prev_above_q <= prev_above_d;
      prev_here_q  <= prev_here_d;
      col_q        <= col_d;
    end
  end

endmodule

// ===== hdl/fcu_queue.sv =====
// ----------------------------------------------------------------------------
// fcu_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module fcu_queue import fcu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fcu_job_t push_job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output fcu_job_t head_job_o
);

  fcu_job_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? (wr_ptr_q + QueuePtrW'(1)) : wr_ptr_q;
    rd_ptr_d = pop_i ? (rd_ptr_q + QueuePtrW'(1)) : rd_ptr_q;
    count_d  = count_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/fcu_back.sv =====
// ----------------------------------------------------------------------------
// fcu_back
// Steps through the head job's pixels, one per cycle unless stalled, computes
// the interpolated chroma and holds each pixel in the output register.
// ----------------------------------------------------------------------------
module fcu_back import fcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  fcu_job_t    head_job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fcu_result_t result_o
);

  // 3:1 vertical blend
  function automatic logic [SampleW-1:0] edge_mix(input logic [SampleW-1:0] near_s,
                                                  input logic [SampleW-1:0] far_s);
    logic [SampleW+1:0] acc;
    acc = (SampleW+2)'(near_s) * (SampleW+2)'(3) + (SampleW+2)'(far_s) + (SampleW+2)'(2);
    return acc[SampleW+1:2];
  endfunction

  // diagonal blend of one channel; returns {top, bottom}
  function automatic logic [2*SampleW-1:0] inner_mix(input logic [SampleW-1:0] tl,
                                                     input logic [SampleW-1:0] t,
                                                     input logic [SampleW-1:0] l,
                                                     input logic [SampleW-1:0] x,
                                                     input logic               second);
    logic [SampleW+3:0] s12;
    logic [SampleW+3:0] s03;
    logic [SampleW+1:0] d12;
    logic [SampleW+1:0] d03;
    logic [SampleW+1:0] top_s;
    logic [SampleW+1:0] bot_s;
    s12 = (SampleW+4)'(tl) + (SampleW+4)'(t) * (SampleW+4)'(3)
        + (SampleW+4)'(l) * (SampleW+4)'(3) + (SampleW+4)'(x) + (SampleW+4)'(8);
    s03 = (SampleW+4)'(tl) * (SampleW+4)'(3) + (SampleW+4)'(t)
        + (SampleW+4)'(l) + (SampleW+4)'(x) * (SampleW+4)'(3) + (SampleW+4)'(8);
    d12 = (SampleW+2)'(s12 >> 3);
    d03 = (SampleW+2)'(s03 >> 3);
    if (second) begin
      top_s = d03 + (SampleW+2)'(t);
      bot_s = d12 + (SampleW+2)'(x);
    end else begin
      top_s = d12 + (SampleW+2)'(tl);
      bot_s = d03 + (SampleW+2)'(l);
    end
    return {top_s[SampleW:1], bot_s[SampleW:1]};
  endfunction

  logic [1:0]           step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  fcu_result_t          result_q, result_d;
  logic                 emit;
  logic                 last_step;
  logic                 use_edge;
  logic [2*SampleW-1:0] mix_u;
  logic [2*SampleW-1:0] mix_v;
  logic [SampleW-1:0]   tu, tv, bu, bv;

  assign emit      = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_step = (step_q == (head_job_i.num_results - 2'd1));
  assign pop_o     = emit && last_step;
  // the first pixel and the trailing pixel of an even line are edge pixels
  assign use_edge  = head_job_i.first_col || (step_q == 2'd2);

  assign mix_u = inner_mix(head_job_i.prev_above_u, head_job_i.above_u,
                           head_job_i.prev_here_u, head_job_i.here_u, step_q[0]);
  assign mix_v = inner_mix(head_job_i.prev_above_v, head_job_i.above_v,
                           head_job_i.prev_here_v, head_job_i.here_v, step_q[0]);

  always_comb begin
    if (use_edge) begin
      tu = edge_mix(head_job_i.above_u, head_job_i.here_u);
      tv = edge_mix(head_job_i.above_v, head_job_i.here_v);
      bu = edge_mix(head_job_i.here_u, head_job_i.above_u);
      bv = edge_mix(head_job_i.here_v, head_job_i.above_v);
    end else begin
      tu = mix_u[2*SampleW-1:SampleW];
      bu = mix_u[SampleW-1:0];
      tv = mix_v[2*SampleW-1:SampleW];
      bv = mix_v[SampleW-1:0];
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d           = 1'b1;
      step_d                = last_step ? 2'd0 : (step_q + 2'd1);
      result_d.pixel_index  = head_job_i.base_index + IndexW'(step_q);
      result_d.top_u        = head_job_i.want_top ? tu : '0;
      result_d.top_v        = head_job_i.want_top ? tv : '0;
      result_d.bottom_u     = head_job_i.want_bottom ? bu : '0;
      result_d.bottom_v     = head_job_i.want_bottom ? bv : '0;
      result_d.top_valid    = head_job_i.want_top;
      result_d.bottom_valid = head_job_i.want_bottom;
      result_d.line_end     = last_step && head_job_i.last_col;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ===== hdl/fancy_chroma_upsampler_unit.sv =====
// ----------------------------------------------------------------------------
// fancy_chroma_upsampler_unit
// 4:2:0 chroma upsampler: one chroma column in, interpolated top and bottom
// row chroma for each luma pixel out.
// ----------------------------------------------------------------------------
// Each request carries one chroma column (above and current chroma row). The
// first column of a line yields one pixel (two when the line is two pixels
// wide), later columns yield two pixels and the last column of an even-width
// line three. The back end emits one pixel per cycle while its output is not
// stalled; the front end takes a new column every cycle while the two-entry
// job queue has room, and the first pixel of a column passes through the job
// queue and then the output register. Write line_width only while no pixels
// are pending.
module fancy_chroma_upsampler_unit import fcu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WidthW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  above_u_i,
  input  logic [SampleW-1:0]  above_v_i,
  input  logic [SampleW-1:0]  here_u_i,
  input  logic [SampleW-1:0]  here_v_i,
  input  logic                want_top_i,
  input  logic                want_bottom_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IndexW-1:0]   pixel_index_o,
  output logic [SampleW-1:0]  top_u_out_o,
  output logic [SampleW-1:0]  top_v_out_o,
  output logic [SampleW-1:0]  bottom_u_out_o,
  output logic [SampleW-1:0]  bottom_v_out_o,
  output logic                top_valid_o,
  output logic                bottom_valid_o,
  output logic                line_end_o
);

  fcu_job_t    push_job;
  fcu_job_t    head_job;
  fcu_result_t result;
  logic        push;
  logic        full;
  logic        pop;
  logic        head_valid;

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  fcu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .above_u_i     (above_u_i),
    .above_v_i     (above_v_i),
    .here_u_i      (here_u_i),
    .here_v_i      (here_v_i),
    .want_top_i    (want_top_i),
    .want_bottom_i (want_bottom_i),
    .job_o         (push_job)
  );

  fcu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  fcu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign pixel_index_o  = result.pixel_index;
  assign top_u_out_o    = result.top_u;
  assign top_v_out_o    = result.top_v;
  assign bottom_u_out_o = result.bottom_u;
  assign bottom_v_out_o = result.bottom_v;
  assign top_valid_o    = result.top_valid;
  assign bottom_valid_o = result.bottom_valid;
  assign line_end_o     = result.line_end;

endmodule

// ===== hdl/fcu_checker.sv =====
// ----------------------------------------------------------------------------
// fcu_checker
// Port-level checks on the upsampler output stream.
// ----------------------------------------------------------------------------
module fcu_checker import fcu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IndexW-1:0]  pixel_index_o,
  input logic [SampleW-1:0] top_u_out_o,
  input logic [SampleW-1:0] top_v_out_o,
  input logic [SampleW-1:0] bottom_u_out_o,
  input logic [SampleW-1:0] bottom_v_out_o,
  input logic               top_valid_o,
  input logic               bottom_valid_o,
  input logic               line_end_o
);

  // a stalled pixel holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_index_o)
      && $stable(line_end_o))
    else $error("stalled output changed");

  // unwanted rows read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !top_valid_o |-> top_u_out_o == '0 && top_v_out_o == '0)
    else $error("unwanted top row not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bottom_valid_o |-> bottom_u_out_o == '0 && bottom_v_out_o == '0)
    else $error("unwanted bottom row not zero");

  // a new line starts at pixel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && line_end_o ##1 out_valid_o |-> pixel_index_o == '0)
    else $error("line did not restart at pixel zero");

  // back-to-back pixels of a line are consecutive, or restart at pixel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !line_end_o ##1 out_valid_o
      |-> pixel_index_o == $past(pixel_index_o) + IndexW'(1) || pixel_index_o == '0)
    else $error("pixel index skipped");

endmodule

bind fancy_chroma_upsampler_unit fcu_checker u_fcu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_index_o  (pixel_index_o),
  .top_u_out_o    (top_u_out_o),
  .top_v_out_o    (top_v_out_o),
  .bottom_u_out_o (bottom_u_out_o),
  .bottom_v_out_o (bottom_v_out_o),
  .top_valid_o    (top_valid_o),
  .bottom_valid_o (bottom_valid_o),
  .line_end_o     (line_end_o)
);
